@@ design/smse_pkg.sv @@
`default_nettype none

package smse_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int STORE_DEPTH = 64;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = AW + 1;
	localparam int KW = 32;
	localparam int PW = 6;
	localparam int RW = KW + PW;

	typedef logic [CW-1:0] count_t;
	typedef logic [AW-1:0] addr_t;

	typedef struct packed {
		logic signed [KW-1:0] key;
		logic [PW-1:0]        pos;
	} record_t;

	typedef struct packed {
		logic load;
		logic close;
		logic seg_start;
		logic read_b;
		logic cap_a;
		logic cap_b;
		logic merge_step;
		logic seg_next;
		logic pass_next;
		logic emit_rd;
		logic emit_ld;
	} smse_cmd_t;

	typedef struct packed {
		logic sort_go;
		logic need_b;
		logic a_live;
		logic b_live;
		logic pick;
		logic refetch;
		logic seg_more;
		logic emit_last;
		logic out_free;
	} smse_sts_t;

endpackage

`default_nettype wire

@@ design/smse_ifs.sv @@
`default_nettype none

interface smse_key_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sort_key;
	logic               batch_end;

	modport source (output valid, output sort_key, output batch_end, input ready);
	modport sink (input valid, input sort_key, input batch_end, output ready);
endinterface

interface smse_rank_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_key;
	logic [5:0]         origin_position;
	logic               final_rank;

	modport source (output valid, output sorted_key, output origin_position,
		output final_rank, input ready);
	modport sink (input valid, input sorted_key, input origin_position,
		input final_rank, output ready);
endinterface

`default_nettype wire

@@ design/smse_ram.sv @@
`default_nettype none

module smse_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/smse_datapath.sv @@
`default_nettype none

module smse_datapath
	import smse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  smse_cmd_t          cmd,
	output smse_sts_t          sts,
	input  logic signed [31:0] in_key,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [31:0] out_key,
	output logic [5:0]         out_pos,
	output logic               out_final
);

	count_t  count_q, n_q, width_q, lo_q, a_q, b_q, k_q;
	addr_t   e_q;
	logic    src_q;
	record_t head_a_q, head_b_q;
	logic    out_valid_q;
	record_t out_rec_q;
	logic    out_final_q;

	logic [CW:0] lo_w, lo_2w, n_ext;
	count_t      mid, hi, a_nx, b_nx;
	logic        full;
	logic        pick;
	record_t     rd0, rd1, rec, merged;
	addr_t       raddr, waddr0;
	record_t     wdata0;
	logic        we0, we1;

	assign n_ext = {1'b0, n_q};
	assign lo_w  = {1'b0, lo_q} + {1'b0, width_q};
	assign lo_2w = lo_w + {1'b0, width_q};
	assign mid   = (lo_w < n_ext) ? lo_w[CW-1:0] : n_q;
	assign hi    = (lo_2w < n_ext) ? lo_2w[CW-1:0] : n_q;
	assign a_nx  = a_q + count_t'(1);
	assign b_nx  = b_q + count_t'(1);
	assign full  = (count_q == count_t'(MAX_RECORDS));

	assign pick = (a_q < mid) && (!(b_q < hi) || ($signed(head_a_q.key) <= $signed(head_b_q.key)));
	assign merged = pick ? head_a_q : head_b_q;
	assign rec    = src_q ? rd1 : rd0;

	always_comb begin
		sts.sort_go   = (width_q < n_q);
		sts.need_b    = (mid < hi);
		sts.a_live    = (a_q < mid);
		sts.b_live    = (b_q < hi);
		sts.pick      = pick;
		sts.refetch   = pick ? (a_nx < mid) : (b_nx < hi);
		sts.seg_more  = (lo_2w < n_ext);
		sts.emit_last = ({1'b0, e_q} == (n_q - count_t'(1)));
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		raddr = '0;
		if (cmd.seg_start) begin
			raddr = lo_q[AW-1:0];
		end else if (cmd.read_b) begin
			raddr = b_q[AW-1:0];
		end else if (cmd.merge_step) begin
			raddr = pick ? a_nx[AW-1:0] : b_nx[AW-1:0];
		end else if (cmd.emit_rd) begin
			raddr = e_q;
		end
	end

	assign we0    = (cmd.load && !full) || (cmd.merge_step && src_q);
	assign we1    = cmd.merge_step && !src_q;
	assign waddr0 = cmd.load ? count_q[AW-1:0] : k_q[AW-1:0];
	assign wdata0 = cmd.load ? record_t'({in_key, count_q[PW-1:0]}) : merged;

	smse_ram #(.WIDTH(RW), .DEPTH(STORE_DEPTH)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr0),
		.wdata (wdata0),
		.raddr (raddr),
		.rdata (rd0)
	);

	smse_ram #(.WIDTH(RW), .DEPTH(STORE_DEPTH)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (k_q[AW-1:0]),
		.wdata (merged),
		.raddr (raddr),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			n_q         <= '0;
			width_q     <= '0;
			lo_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			src_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && !full) begin
				count_q <= count_q + count_t'(1);
			end
			if (cmd.close) begin
				n_q     <= full ? count_q : count_q + count_t'(1);
				count_q <= '0;
				width_q <= count_t'(1);
				lo_q    <= '0;
				src_q   <= 1'b0;
				e_q     <= '0;
			end
			if (cmd.seg_start) begin
				a_q <= lo_q;
				b_q <= mid;
				k_q <= lo_q;
			end
			if (cmd.merge_step) begin
				k_q <= k_q + count_t'(1);
				if (pick) begin
					a_q <= a_nx;
				end else begin
					b_q <= b_nx;
				end
			end
			if (cmd.seg_next) begin
				lo_q <= lo_2w[CW-1:0];
			end
			if (cmd.pass_next) begin
				width_q <= width_q << 1;
				lo_q    <= '0;
				src_q   <= !src_q;
			end
			if (cmd.emit_ld) begin
				e_q         <= e_q + addr_t'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			head_a_q <= rec;
		end
		if (cmd.cap_b) begin
			head_b_q <= rec;
		end
		if (cmd.emit_ld) begin
			out_rec_q   <= rec;
			out_final_q <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_key   = out_rec_q.key;
	assign out_pos   = out_rec_q.pos;
	assign out_final = out_final_q;

endmodule

`default_nettype wire

@@ design/smse_ctrl.sv @@
`default_nettype none

module smse_ctrl
	import smse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  smse_sts_t sts,
	output smse_cmd_t cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_START   = 3'd1;
	localparam logic [2:0] S_INITA   = 3'd2;
	localparam logic [2:0] S_CAPA    = 3'd3;
	localparam logic [2:0] S_CAPB    = 3'd4;
	localparam logic [2:0] S_MERGE   = 3'd5;
	localparam logic [2:0] S_EMIT_RD = 3'd6;
	localparam logic [2:0] S_EMIT_LD = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.close = 1'b1;
						state_d   = S_START;
					end
				end
			end
			S_START: begin
				if (sts.sort_go) begin
					cmd.seg_start = 1'b1;
					state_d       = S_INITA;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_INITA: begin
				cmd.cap_a = 1'b1;
				if (sts.need_b) begin
					cmd.read_b = 1'b1;
					state_d    = S_CAPB;
				end else begin
					state_d = S_MERGE;
				end
			end
			S_CAPA: begin
				cmd.cap_a = 1'b1;
				state_d   = S_MERGE;
			end
			S_CAPB: begin
				cmd.cap_b = 1'b1;
				state_d   = S_MERGE;
			end
			S_MERGE: begin
				if (sts.a_live || sts.b_live) begin
					cmd.merge_step = 1'b1;
					if (sts.refetch) begin
						state_d = sts.pick ? S_CAPA : S_CAPB;
					end
				end else begin
					if (sts.seg_more) begin
						cmd.seg_next = 1'b1;
					end else begin
						cmd.pass_next = 1'b1;
					end
					state_d = S_START;
				end
			end
			S_EMIT_RD: begin
				if (sts.out_free) begin
					cmd.emit_rd = 1'b1;
					state_d     = S_EMIT_LD;
				end
			end
			S_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				state_d     = sts.emit_last ? S_IDLE : S_EMIT_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ design/stable_merge_sort_engine.sv @@
// Stable merge sort engine for batches of up to 64 signed 32-bit keys.
// Keys arrive on the keys channel, one request per cycle while the engine is
// loading; batch_end on a request closes the batch. Keys past the 64th are
// dropped, but a dropped key with batch_end still closes the batch.
// After the close the engine stops taking requests, sorts the batch in
// ascending order with a bottom-up merge that keeps equal keys in arrival
// order, and sends one request per record on the ranks channel: the key, its
// arrival position, and final_rank on the last one.
// Records live in two single-port-read RAM banks that swap roles each pass.
// One read per cycle sets the pace: each run pair starts by reading the head
// of each of its runs, each merged record is followed by a read of the next
// head of the run it came from while that run lasts, and each emitted result
// is read from RAM and then loaded into the output register.
// A stalled receiver holds the engine in emission; one result waits in an
// output register and the next RAM read starts only once it has left.
// Loading of the next batch begins as soon as the last result is registered.
// Reset clears the fill count, the state machine and the output valid; the
// RAM contents are not cleared and are never read before being written.
`default_nettype none

module stable_merge_sort_engine
	import smse_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	smse_key_if.sink     keys,
	smse_rank_if.source  ranks
);

	smse_cmd_t cmd;
	smse_sts_t sts;

	smse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (keys.valid),
		.in_last  (keys.batch_end),
		.in_ready (keys.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smse_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_key    (keys.sort_key),
		.out_ready (ranks.ready),
		.out_valid (ranks.valid),
		.out_key   (ranks.sorted_key),
		.out_pos   (ranks.origin_position),
		.out_final (ranks.final_rank)
	);

endmodule

`default_nettype wire

@@ verif/smse_rank_checker.sv @@
`default_nettype none

// Watches both channels, rebuilds each batch from the key requests, and
// checks every rank request against the stable ascending order of that batch.
module smse_rank_checker
	import smse_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	smse_key_if   keys,
	smse_rank_if  ranks,
	output int    mismatch_count,
	output int    outstanding
);

	typedef struct packed {
		logic signed [KW-1:0] key;
		logic [PW-1:0]        pos;
		logic                 last;
	} rank_t;

	record_t batch[MAX_RECORDS];
	int      batch_fill = 0;
	rank_t   ranks_due[$];
	int      errors = 0;

	// Insertion sort with a strict comparison, so equal keys keep arrival order.
	task automatic rank_batch();
		record_t ordered[MAX_RECORDS];
		record_t moving;
		rank_t   due;
		int      j;
		for (int i = 0; i < batch_fill; i++) begin
			moving = batch[i];
			j = i;
			while (j > 0 && $signed(ordered[j-1].key) > $signed(moving.key)) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = moving;
		end
		for (int i = 0; i < batch_fill; i++) begin
			due.key = ordered[i].key;
			due.pos = ordered[i].pos;
			due.last = (i == batch_fill - 1);
			ranks_due.push_back(due);
		end
		batch_fill = 0;
	endtask

	always @(posedge clk) begin
		rank_t due;
		rank_t seen;
		if (!arst_n) begin
			batch_fill = 0;
			ranks_due.delete();
		end else begin
			if (ranks.valid && ranks.ready) begin
				seen.key = ranks.sorted_key;
				seen.pos = ranks.origin_position;
				seen.last = ranks.final_rank;
				if (ranks_due.size() == 0) begin
					errors++;
					$display("%0t: rank request with none expected: expected none, got key %0d pos %0d last %0b",
						$time, seen.key, seen.pos, seen.last);
				end else begin
					due = ranks_due.pop_front();
					if (due !== seen) begin
						errors++;
						$display("%0t: rank mismatch: expected key %0d pos %0d last %0b, got key %0d pos %0d last %0b",
							$time, due.key, due.pos, due.last, seen.key, seen.pos, seen.last);
					end
				end
			end
			if (keys.valid && keys.ready) begin
				if (batch_fill < MAX_RECORDS) begin
					batch[batch_fill].key = keys.sort_key;
					batch[batch_fill].pos = PW'(batch_fill);
					batch_fill++;
				end
				if (keys.batch_end) begin
					rank_batch();
				end
			end
		end
		mismatch_count <= errors;
		outstanding <= ranks_due.size();
	end

endmodule

`default_nettype wire

@@ verif/stable_merge_sort_engine_test.sv @@
`default_nettype none

module stable_merge_sort_engine_test;
	import smse_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int LONG_HOLD = 600;
	localparam int ITEM_GOAL = 250;
	localparam int QUIET_FROM = 205;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   outstanding;
	int   keys_sent = 0;
	bit   quiet = 1'b0;
	bit   rx_hold_req = 1'b0;

	logic signed [31:0] staged[$];

	smse_key_if  keys();
	smse_rank_if ranks();

	stable_merge_sort_engine u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.keys  (keys),
		.ranks (ranks)
	);

	smse_rank_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.keys          (keys),
		.ranks         (ranks),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic signed [31:0] draw_key(input int flavor);
		case (flavor)
			1: begin
				return int'($urandom_range(0, 6)) - 3;
			end
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic pause_keys(input int cycles);
		keys.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_gap(input int gap_odds);
		if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			pause_keys($urandom_range(1, 13));
		end
	endtask

	// Returns at the edge where the request is taken, with valid still high.
	task automatic offer_key(input logic signed [31:0] key, input logic last);
		keys.valid <= 1'b1;
		keys.sort_key <= key;
		keys.batch_end <= last;
		@(posedge clk);
		while (!keys.ready) @(posedge clk);
		keys_sent++;
	endtask

	task automatic send_staged(input int gap_odds);
		for (int i = 0; i < staged.size(); i++) begin
			maybe_gap(gap_odds);
			offer_key(staged[i], i == staged.size() - 1);
		end
	endtask

	task automatic send_batch(input int size, input int flavor, input int gap_odds);
		for (int i = 0; i < size; i++) begin
			maybe_gap(gap_odds);
			offer_key(draw_key(flavor), i == size - 1);
		end
	endtask

	task automatic drain_ranks();
		keys.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		ranks.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				ranks.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				ranks.ready <= 1'b0;
			end else if (quiet || calm_left > 0) begin
				if (calm_left > 0) begin
					calm_left--;
				end
				ranks.ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						calm_left = $urandom_range(30, 120);
						ranks.ready <= 1'b1;
					end
					1, 2, 3: begin
						stall_left = $urandom_range(1, 13) - 1;
						ranks.ready <= 1'b0;
					end
					default: begin
						ranks.ready <= 1'b1;
					end
				endcase
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((keys.valid && keys.ready) || (ranks.valid && ranks.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int size;
		int pick;
		int odds;
		keys.valid <= 1'b0;
		keys.sort_key <= '0;
		keys.batch_end <= 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		staged = '{32'sd0};
		send_staged(0);
		staged = '{32'sd7, -32'sd3, 32'sd7, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd3,
			32'sd7, 32'sd1, -32'sd1, 32'sd0};
		send_staged(3);
		staged = '{32'sd5, 32'sd4};
		send_staged(0);
		staged = '{-32'sd8, -32'sd8, -32'sd8, -32'sd8};
		send_staged(2);
		staged = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sh7FFF_FFFF};
		send_staged(0);
		staged = '{32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000};
		send_staged(4);
		drain_ranks();

		// Two keys past a full batch; the second of them closes it.
		send_batch(MAX_RECORDS + 2, 0, 8);

		// The receiver holds off while two batches are offered, so the engine
		// ends up stalled in emission with the next batch waiting at its input.
		drain_ranks();
		@(negedge clk);
		rx_hold_req = 1'b1;
		@(posedge clk);
		send_batch(24, 1, 0);
		send_batch(12, 0, 0);
		drain_ranks();

		while (keys_sent < ITEM_GOAL) begin
			quiet = (keys_sent >= QUIET_FROM);
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				size = $urandom_range(60, 70);
			end else if (pick <= 4) begin
				size = $urandom_range(13, 32);
			end else begin
				size = $urandom_range(1, 12);
			end
			if (size > ITEM_GOAL - keys_sent) begin
				size = ITEM_GOAL - keys_sent;
			end
			if (quiet || $urandom_range(0, 2) == 0) begin
				odds = 0;
			end else begin
				odds = $urandom_range(2, 6);
			end
			send_batch(size, $urandom_range(0, 2), odds);
			if (!quiet && $urandom_range(0, 6) == 0) begin
				drain_ranks();
			end
		end

		drain_ranks();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
